// ===== hdl/swept_aabb_entry_time_defines.svh =====
// ----------------------------------------------------------------------------
// Swept box entry time: assertion macros
// Shared assertion forms for the swept box entry time block.
// ----------------------------------------------------------------------------
`ifndef SWEPT_AABB_ENTRY_TIME_DEFINES_SVH
`define SWEPT_AABB_ENTRY_TIME_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SATE_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("swept box entry time assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SATE_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("swept box entry time assertion failed");

`endif

// ===== hdl/sate_pkg.sv =====
// ----------------------------------------------------------------------------
// Swept box entry time package
// Default widths, register indexes and the side-band tag of the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package sate_pkg;

    localparam int SATE_COORD_WIDTH = 32;
    localparam int SATE_FRAC_BITS   = 16;
    localparam int SATE_IDX_W       = 3;

    typedef enum logic [SATE_IDX_W-1:0] {
        REG_MOVER_SIZE_X  = 3'd0,
        REG_MOVER_SIZE_Y  = 3'd1,
        REG_MOVER_SIZE_Z  = 3'd2,
        REG_STATIC_SIZE_X = 3'd3,
        REG_STATIC_SIZE_Y = 3'd4,
        REG_STATIC_SIZE_Z = 3'd5
    } sate_reg_idx_t;

    // Per item flags that ride alongside the division lanes.
    // Lanes 0..2 are entry x/y/z, lanes 3..5 are exit x/y/z.
    typedef struct packed {
        logic [2:0] vzero;
        logic [2:0] gneg;
        logic [5:0] neg;
        logic [5:0] sat;
    } sate_tag_t;

endpackage

`default_nettype wire

// ===== hdl/sate_div_cell.sv =====
// ----------------------------------------------------------------------------
// Swept box entry time: divider cell
// One restoring division step of one lane; registers remainder, divisor and
// partial quotient and hands them to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module sate_div_cell
    import sate_pkg::*;
#(
    parameter int RW    = SATE_COORD_WIDTH + 2,
    parameter int QW    = SATE_FRAC_BITS + 1,
    parameter bit SHIFT = 1'b1
)
(
    input  wire logic          clk,
    input  wire logic [RW-1:0] rem_in,
    input  wire logic [RW-1:0] den_in,
    input  wire logic [QW-1:0] q_in,
    output logic      [RW-1:0] rem_out,
    output logic      [RW-1:0] den_out,
    output logic      [QW-1:0] q_out
);

    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] den_reg;
    logic [QW-1:0] q_reg, q_next;
    logic [RW-1:0] trial;
    logic          ge;

    always_comb
    begin
        trial    = SHIFT ? {rem_in[RW-2:0], 1'b0} : rem_in;
        ge       = (trial >= den_in);
        rem_next = ge ? (trial - den_in) : trial;
        q_next   = {q_in[QW-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        q_reg   <= q_next;
    end

    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

// ===== hdl/swept_aabb_entry_time.sv =====
// ----------------------------------------------------------------------------
// Swept box entry time
// Slab test of a moving box against a static box: entry time and hit face.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     start / busy           mover_min_*, vel_*, static_min_*
//  result    done (one cycle)       entry_time, hit, normal_axis, normal_positive
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per cycle; busy stays low. A result passes through one gap
//  stage, the FRAC_BITS+1 cell divider chain, and the resolve and decision
//  stages. Reset clears valid flags and restores all sizes to 1.0. The
//  receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
`default_nettype none
`include "swept_aabb_entry_time_defines.svh"

module swept_aabb_entry_time
    import sate_pkg::*;
#(
    parameter int COORD_WIDTH = SATE_COORD_WIDTH,
    parameter int FRAC_BITS   = SATE_FRAC_BITS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] mover_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] mover_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] mover_min_z,
    input  wire logic signed [COORD_WIDTH-1:0] vel_x,
    input  wire logic signed [COORD_WIDTH-1:0] vel_y,
    input  wire logic signed [COORD_WIDTH-1:0] vel_z,
    input  wire logic signed [COORD_WIDTH-1:0] static_min_x,
    input  wire logic signed [COORD_WIDTH-1:0] static_min_y,
    input  wire logic signed [COORD_WIDTH-1:0] static_min_z,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [SATE_IDX_W-1:0]         cfg_index,
    input  wire logic [COORD_WIDTH-2:0]        cfg_data,
    output logic                               done,
    output logic [FRAC_BITS:0]                 entry_time,
    output logic                               hit,
    output logic [1:0]                         normal_axis,
    output logic                               normal_positive
);

    localparam int GW    = COORD_WIDTH + 2;   // gap width, signed
    localparam int RW    = COORD_WIDTH + 2;   // remainder width
    localparam int QW    = FRAC_BITS + 1;     // quotient bits
    localparam int TW    = FRAC_BITS + 3;     // signed time width
    localparam int NCELL = FRAC_BITS + 1;
    localparam logic signed [TW-1:0] T_ONE  = TW'(1) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] T_SAT  = TW'(2) <<< FRAC_BITS;
    localparam logic signed [TW-1:0] T_NINF = -T_SAT - TW'(1);
    localparam logic signed [TW-1:0] T_PINF = T_SAT + TW'(1);
    localparam logic [COORD_WIDTH-2:0] SIZE_RST = (COORD_WIDTH-1)'(1) << FRAC_BITS;

    // configuration
    logic [COORD_WIDTH-2:0] msize_reg [3];
    logic [COORD_WIDTH-2:0] ssize_reg [3];

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                msize_reg[i] <= SIZE_RST;
                ssize_reg[i] <= SIZE_RST;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sate_reg_idx_t'(cfg_index))
                REG_MOVER_SIZE_X:  msize_reg[0] <= cfg_data;
                REG_MOVER_SIZE_Y:  msize_reg[1] <= cfg_data;
                REG_MOVER_SIZE_Z:  msize_reg[2] <= cfg_data;
                REG_STATIC_SIZE_X: ssize_reg[0] <= cfg_data;
                REG_STATIC_SIZE_Y: ssize_reg[1] <= cfg_data;
                REG_STATIC_SIZE_Z: ssize_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // gap stage
    logic signed [COORD_WIDTH-1:0] mmin [3];
    logic signed [COORD_WIDTH-1:0] vel  [3];
    logic signed [COORD_WIDTH-1:0] smin [3];

    assign mmin[0] = mover_min_x;
    assign mmin[1] = mover_min_y;
    assign mmin[2] = mover_min_z;
    assign vel[0]  = vel_x;
    assign vel[1]  = vel_y;
    assign vel[2]  = vel_z;
    assign smin[0] = static_min_x;
    assign smin[1] = static_min_y;
    assign smin[2] = static_min_z;

    logic [RW-1:0] rem0_next [6];
    logic [RW-1:0] den0_next [6];
    sate_tag_t     tag0_next;

    always_comb
    begin
        logic signed [GW-1:0] mlo, mhi, slo, shi, gin, gout, g;
        logic [RW-1:0]        ud, un;
        tag0_next = '0;
        for (int a = 0; a < 3; a++)
        begin
            mlo  = GW'(mmin[a]);
            slo  = GW'(smin[a]);
            mhi  = mlo + $signed({2'b00, msize_reg[a], 1'b0} >> 1);
            shi  = slo + $signed({2'b00, ssize_reg[a], 1'b0} >> 1);
            if (vel[a] > 0)
            begin
                gin  = slo - mhi;
                gout = shi - mlo;
            end
            else
            begin
                gin  = shi - mlo;
                gout = slo - mhi;
            end
            ud = vel[a][COORD_WIDTH-1] ? RW'(-GW'(vel[a])) : RW'(GW'(vel[a]));
            tag0_next.vzero[a] = (vel[a] == 0);
            tag0_next.gneg[a]  = gin[GW-1];
            for (int e = 0; e < 2; e++)
            begin
                g  = (e == 0) ? gin : gout;
                un = g[GW-1] ? RW'(-g) : RW'(g);
                rem0_next[a + 3*e]     = un;
                den0_next[a + 3*e]     = ud;
                tag0_next.neg[a + 3*e] = g[GW-1] ^ vel[a][COORD_WIDTH-1];
                tag0_next.sat[a + 3*e] = ({1'b0, un} >= {ud, 1'b0});
            end
        end
    end

    // divider chain: level 0 feeds cell row 0, level NCELL leaves the last row
    logic [RW-1:0] rem_l [NCELL+1][6];
    logic [RW-1:0] den_l [NCELL+1][6];
    logic [QW-1:0] q_l   [NCELL+1][6];
    sate_tag_t     tag_reg [NCELL+1];
    logic          vld_reg [NCELL+1];

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 6; l++)
        begin
            rem_l[0][l] <= rem0_next[l];
            den_l[0][l] <= den0_next[l];
            q_l[0][l]   <= '0;
        end
        tag_reg[0] <= tag0_next;
        for (int s = 1; s <= NCELL; s++)
            tag_reg[s] <= tag_reg[s-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NCELL; s++)
                vld_reg[s] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int s = 1; s <= NCELL; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    for (genvar s = 0; s < NCELL; s++)
    begin : g_step
        for (genvar l = 0; l < 6; l++)
        begin : g_lane
            sate_div_cell #(
                .RW    (RW),
                .QW    (QW),
                .SHIFT (s != 0)
            ) u_cell (
                .clk     (clk),
                .rem_in  (rem_l[s][l]),
                .den_in  (den_l[s][l]),
                .q_in    (q_l[s][l]),
                .rem_out (rem_l[s+1][l]),
                .den_out (den_l[s+1][l]),
                .q_out   (q_l[s+1][l])
            );
        end
    end

    // resolve stage: signed, saturated times
    logic signed [TW-1:0] time_reg [6];
    logic signed [TW-1:0] time_next [6];
    logic [2:0]           gneg_reg;
    logic                 vld_res_reg;

    always_comb
    begin
        logic signed [TW-1:0] mag;
        sate_tag_t            tg;
        tg = tag_reg[NCELL];
        for (int l = 0; l < 6; l++)
        begin
            mag = tg.sat[l] ? T_SAT : $signed({2'b00, q_l[NCELL][l]});
            if (tg.neg[l])
                time_next[l] = -mag - TW'(!tg.sat[l] && (rem_l[NCELL][l] != '0));
            else
                time_next[l] = mag;
            if (tg.vzero[l % 3])
                time_next[l] = (l < 3) ? T_NINF : T_PINF;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 6; l++)
            time_reg[l] <= time_next[l];
        gneg_reg <= tag_reg[NCELL].gneg;
    end

    // decision stage
    logic [FRAC_BITS:0] et_next;
    logic               hit_next;
    logic [1:0]         axis_next;
    logic               pos_next;

    always_comb
    begin
        logic signed [TW-1:0] t_in, t_out;
        logic                 all_neg, any_late;
        logic [1:0]           ax;
        all_neg  = 1'b1;
        any_late = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            if (time_reg[a] >= 0)
                all_neg = 1'b0;
            if (time_reg[a] > T_ONE)
                any_late = 1'b1;
        end
        if (time_reg[0] >= time_reg[1] && time_reg[0] >= time_reg[2])
            ax = 2'd0;
        else if (time_reg[1] >= time_reg[2])
            ax = 2'd1;
        else
            ax = 2'd2;
        t_in  = time_reg[ax];
        t_out = time_reg[3];
        if (time_reg[4] < t_out)
            t_out = time_reg[4];
        if (time_reg[5] < t_out)
            t_out = time_reg[5];
        if (t_in > t_out || all_neg || any_late)
        begin
            et_next   = T_ONE[FRAC_BITS:0];
            hit_next  = 1'b0;
            axis_next = 2'd0;
            pos_next  = 1'b0;
        end
        else
        begin
            et_next   = t_in[FRAC_BITS:0];
            hit_next  = 1'b1;
            axis_next = ax + 2'd1;
            pos_next  = gneg_reg[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        entry_time      <= et_next;
        hit             <= hit_next;
        normal_axis     <= axis_next;
        normal_positive <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_res_reg <= 1'b0;
            done        <= 1'b0;
        end
        else
        begin
            vld_res_reg <= vld_reg[NCELL];
            done        <= vld_res_reg;
        end
    end

    `SATE_ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##(FRAC_BITS+4) done)
    `SATE_ASSERT_IMP(a_miss_form, clk, rst_n, done && !hit,
        entry_time == T_ONE[FRAC_BITS:0] && normal_axis == 2'd0 && !normal_positive)
    `SATE_ASSERT_IMP(a_hit_form, clk, rst_n, done && hit,
        normal_axis != 2'd0 && entry_time <= T_ONE[FRAC_BITS:0])
    `SATE_ASSERT_NXT(a_no_orphan, clk, rst_n, !vld_res_reg, !done)

endmodule

`default_nettype wire
